// File: design/bc4_bc5_block_decoder_assert.svh
// Assertion macros for the BC4/BC5 block decoder.
// Uses the clk and rst_n names of the module that includes it.
`ifndef BC4_BC5_BLOCK_DECODER_ASSERT_SVH
`define BC4_BC5_BLOCK_DECODER_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define BC45_ASSERT_HOLD(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define BC45_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/bc45_pkg.sv
// Shared types and constants for the BC4/BC5 block decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bc45_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned PIX_W       = 4;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned IDX_BASE    = 16;
    localparam logic [PIX_W-1:0] LAST_PIX = 4'd15;

    // register indexes on the config port
    localparam logic REG_SIGNED_FORMAT = 1'b0;
    localparam logic REG_TWO_CHANNEL   = 1'b1;

    localparam logic [7:0] ALPHA_UNORM = 8'hFF;
    localparam logic [7:0] ALPHA_SNORM = 8'h7F;

    // floor(x/d) = (x * ceil(2^14/d)) >> 14, exact for x < 2048
    localparam int unsigned RECIP_SHIFT = 14;
    localparam logic [11:0] RECIP_DIV7  = 12'd2341;
    localparam logic [11:0] RECIP_DIV5  = 12'd3277;

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pix;
        logic             last;
    } pixel_issue_t;

endpackage

`default_nettype wire

// File: design/bc45_seq.sv
// Block holding register and pixel counter for the BC4/BC5 decoder.
// Depends on bc45_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "bc4_bc5_block_decoder_assert.svh"

module bc45_seq
    import bc45_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [127:0]       s_tdata,   // block_first[63:0], block_second[127:64]
    input  wire logic               pipe_en,
    output logic [WORD_W-1:0]       word_first,
    output logic [WORD_W-1:0]       word_second,
    output pixel_issue_t            issue
);

    logic               blk_valid_reg;
    logic               blk_valid_next;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   pix_next;
    logic [WORD_W-1:0]  first_reg;
    logic [WORD_W-1:0]  second_reg;
    logic               issue_fire;
    logic               accept;

    assign issue_fire = blk_valid_reg && pipe_en;
    // next block is taken in the cycle the sixteenth pixel leaves
    assign s_tready   = !blk_valid_reg || (issue_fire && (pix_reg == LAST_PIX));
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        pix_next       = pix_reg;
        if (issue_fire)
        begin
            pix_next = pix_reg + 4'd1;
            if (pix_reg == LAST_PIX)
            begin
                blk_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            blk_valid_next = 1'b1;
            pix_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            pix_reg       <= '0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            pix_reg       <= pix_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            first_reg  <= s_tdata[63:0];
            second_reg <= s_tdata[127:64];
        end
    end

    assign word_first  = first_reg;
    assign word_second = second_reg;
    assign issue.valid = issue_fire;
    assign issue.pix   = pix_reg;
    assign issue.last  = (pix_reg == LAST_PIX);

    `BC45_ASSERT_HOLD(a_accept_only_at_end, !(s_tready && blk_valid_reg) || (pix_reg == LAST_PIX))
    `BC45_ASSERT_NEXT(a_pix_advances, blk_valid_reg && pipe_en && (pix_reg != LAST_PIX),
                      blk_valid_reg && (pix_reg == $past(pix_reg) + 4'd1))

endmodule

`default_nettype wire

// File: design/bc45_chan.sv
// Four-stage channel pipeline: index select, weighted sum, reciprocal
// multiply, sign fix-up and select. Depends on bc45_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bc45_chan
    import bc45_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic               signed_fmt,
    input  wire logic [WORD_W-1:0]  word,
    input  wire logic [PIX_W-1:0]   pix,
    output logic [7:0]              value
);

    // stage 0: endpoints and index
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       e0_reg, e1_reg;
    logic             sgn0_reg;

    // stage 1: weighted sum
    logic [10:0]      x_reg;
    logic             neg1_reg, div5_reg, interp1_reg;
    logic [7:0]       direct1_reg;

    // stage 2: reciprocal product
    logic [22:0]      prod_reg;
    logic             neg2_reg, interp2_reg;
    logic [7:0]       direct2_reg;

    // stage 3: result
    logic [7:0]       value_reg;

    logic [IDX_W-1:0] idx_sel;
    logic             mode8;
    logic [7:0]       v0_byte, v1_byte;
    logic signed [11:0] v0_ext, v1_ext, w0_ext, w1_ext, n_sum;
    logic [2:0]       w0, w1;
    logic [10:0]      x_next;
    logic             neg_next, interp_next;
    logic [7:0]       direct_next;
    logic [7:0]       q;

    assign idx_sel = word[IDX_BASE + IDX_W * pix +: IDX_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg  <= idx_sel;
            e0_reg   <= word[7:0];
            e1_reg   <= word[15:8];
            sgn0_reg <= signed_fmt;
        end
    end

    always_comb
    begin
        mode8   = sgn0_reg ? ($signed(e0_reg) > $signed(e1_reg)) : (e0_reg > e1_reg);
        // -128 maps to -127 in signed mode
        v0_byte = (sgn0_reg && (e0_reg == 8'h80)) ? 8'h81 : e0_reg;
        v1_byte = (sgn0_reg && (e1_reg == 8'h80)) ? 8'h81 : e1_reg;
        v0_ext  = sgn0_reg ? {{4{v0_byte[7]}}, v0_byte} : {4'b0, v0_byte};
        v1_ext  = sgn0_reg ? {{4{v1_byte[7]}}, v1_byte} : {4'b0, v1_byte};
        w0      = mode8 ? 3'(4'd8 - {1'b0, idx_reg}) : 3'(4'd6 - {1'b0, idx_reg});
        w1      = idx_reg - 3'd1;
        w0_ext  = {9'b0, w0};
        w1_ext  = {9'b0, w1};
        n_sum   = w0_ext * v0_ext + w1_ext * v1_ext;

        if (sgn0_reg)
        begin
            neg_next = n_sum[11];
            x_next   = n_sum[11] ? 11'(-n_sum) : n_sum[10:0];
        end
        else
        begin
            neg_next = 1'b0;
            // bias gives round-to-nearest after the floor divide
            x_next   = n_sum[10:0] + (mode8 ? 11'd3 : 11'd2);
        end

        interp_next = (idx_reg >= 3'd2) && (mode8 || (idx_reg <= 3'd5));

        case (idx_reg)
            3'd0:    direct_next = v0_byte;
            3'd1:    direct_next = v1_byte;
            3'd6:    direct_next = sgn0_reg ? 8'h81 : 8'h00;
            default: direct_next = sgn0_reg ? 8'h7F : 8'hFF;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg       <= x_next;
            neg1_reg    <= neg_next;
            div5_reg    <= !mode8;
            interp1_reg <= interp_next;
            direct1_reg <= direct_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg    <= x_reg * (div5_reg ? RECIP_DIV5 : RECIP_DIV7);
            neg2_reg    <= neg1_reg;
            interp2_reg <= interp1_reg;
            direct2_reg <= direct1_reg;
        end
    end

    assign q = prod_reg[RECIP_SHIFT +: 8];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (interp2_reg)
            begin
                value_reg <= neg2_reg ? 8'(~q + 8'd1) : q;
            end
            else
            begin
                value_reg <= direct2_reg;
            end
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: design/bc4_bc5_block_decoder.sv
// BC4/BC5 block decoder: one 128-bit block beat in, sixteen pixel beats out.
// After a block is accepted its pixels leave one per cycle while m_tready does not hold the output;
// the channel pipeline takes one pixel per cycle, and the next block is taken as the previous
// one's last pixel enters the pipeline.
// Reset (rst_n, async, active low) clears config registers and all valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "bc4_bc5_block_decoder_assert.svh"

module bc4_bc5_block_decoder
    import bc45_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic         cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // block_first[63:0], block_second[127:64]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // pixel_index[3:0], red[11:4], green[19:12],
                                         // blue[27:20], alpha[35:28], zero pad[39:36]
    output logic              m_tlast    // last_pixel
);

    localparam int unsigned DEPTH = 4;

    logic                signed_reg;
    logic                two_chan_reg;
    logic                pipe_en;
    logic [WORD_W-1:0]   word_first, word_second;
    pixel_issue_t        issue;
    logic [DEPTH-1:0]    vld_reg;
    logic [PIX_W-1:0]    pix_reg  [DEPTH];
    logic [DEPTH-1:0]    last_reg;
    logic [7:0]          red, green_raw;
    logic [7:0]          green, blue, alpha;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_reg   <= 1'b0;
            two_chan_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIGNED_FORMAT: signed_reg   <= cfg_data;
                REG_TWO_CHANNEL:   two_chan_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // whole pipeline moves unless the output beat is held
    assign pipe_en = !vld_reg[DEPTH-1] || m_tready;

    bc45_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .pipe_en     (pipe_en),
        .word_first  (word_first),
        .word_second (word_second),
        .issue       (issue)
    );

    bc45_chan u_chan_first (
        .clk        (clk),
        .en         (pipe_en),
        .signed_fmt (signed_reg),
        .word       (word_first),
        .pix        (issue.pix),
        .value      (red)
    );

    bc45_chan u_chan_second (
        .clk        (clk),
        .en         (pipe_en),
        .signed_fmt (signed_reg),
        .word       (word_second),
        .pix        (issue.pix),
        .value      (green_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], issue.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pix_reg[0]  <= issue.pix;
            last_reg[0] <= issue.last;
            for (int k = 1; k < DEPTH; k++)
            begin
                pix_reg[k]  <= pix_reg[k-1];
                last_reg[k] <= last_reg[k-1];
            end
        end
    end

    assign green = two_chan_reg ? green_raw : red;
    assign blue  = two_chan_reg ? 8'h00 : red;
    assign alpha = signed_reg ? ALPHA_SNORM : ALPHA_UNORM;

    assign m_tvalid = vld_reg[DEPTH-1];
    assign m_tlast  = last_reg[DEPTH-1];
    assign m_tdata  = {4'b0, alpha, blue, green, red, pix_reg[DEPTH-1]};

    `BC45_ASSERT_HOLD(a_last_is_pix15, !(m_tvalid && m_tlast) || (m_tdata[3:0] == LAST_PIX))
    `BC45_ASSERT_HOLD(a_pix15_is_last, !(m_tvalid && (m_tdata[3:0] == LAST_PIX)) || m_tlast)

endmodule

`default_nettype wire

// File: dv/bc4_bc5_block_decoder_checker.sv
// Scoreboard for the BC4/BC5 block decoder: watches the config, block and pixel ports,
// predicts sixteen pixels per accepted block and compares every pixel beat.
// Depends on bc45_pkg.
`timescale 1ns / 1ps

module bc4_bc5_block_decoder_checker
    import bc45_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_index,
    input  wire logic         cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [39:0]  m_tdata,
    input  wire logic         m_tlast,
    output int                fail_count,
    output int                pending,
    output int                pixels_checked
);

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic             last;
    } pixel_t;

    logic   snorm_mode;
    logic   bc5_mode;
    pixel_t expected_pixels[$];

    // One palette lookup for one channel word and pixel position.
    function automatic logic [7:0] decode_texel(logic [WORD_W-1:0] word, int pix,
                                                logic snorm);
        int raw0;
        int raw1;
        int s0;
        int s1;
        int i;
        int n;
        int v;
        logic eight_entry;
        i = int'(word[IDX_BASE + IDX_W*pix +: IDX_W]);
        if (snorm)
        begin
            raw0 = $signed(word[7:0]);
            raw1 = $signed(word[15:8]);
            // mode test uses the raw bytes, before -128 is folded to -127
            s0 = (raw0 == -128) ? -127 : raw0;
            s1 = (raw1 == -128) ? -127 : raw1;
        end
        else
        begin
            raw0 = int'(word[7:0]);
            raw1 = int'(word[15:8]);
            s0 = raw0;
            s1 = raw1;
        end
        eight_entry = (raw0 > raw1);
        if (i == 0)
            v = s0;
        else if (i == 1)
            v = s1;
        else if (eight_entry)
        begin
            n = (8 - i) * s0 + (i - 1) * s1;
            v = snorm ? n / 7 : (2 * n + 7) / 14;
        end
        else if (i == 6)
            v = snorm ? -127 : 0;
        else if (i == 7)
            v = snorm ? 127 : 255;
        else
        begin
            n = (6 - i) * s0 + (i - 1) * s1;
            v = snorm ? n / 5 : (2 * n + 5) / 10;
        end
        return v[7:0];
    endfunction

    function automatic bit field_bad(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        pixel_t px;
        bit     bad;
        if (!rst_n)
        begin
            snorm_mode = 1'b0;
            bc5_mode = 1'b0;
            expected_pixels.delete();
            fail_count = 0;
            pending = 0;
            pixels_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SIGNED_FORMAT: snorm_mode = cfg_data;
                    REG_TWO_CHANNEL:   bc5_mode = cfg_data;
                    default:           ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                for (int p = 0; p < 16; p++)
                begin
                    px.pix = p[PIX_W-1:0];
                    px.red = decode_texel(s_tdata[63:0], p, snorm_mode);
                    px.green = bc5_mode ? decode_texel(s_tdata[127:64], p, snorm_mode)
                                        : px.red;
                    px.blue = bc5_mode ? 8'h00 : px.red;
                    px.alpha = snorm_mode ? ALPHA_SNORM : ALPHA_UNORM;
                    px.last = (px.pix == LAST_PIX);
                    expected_pixels.push_back(px);
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel beat with no block outstanding: tdata 'h%0h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    px = expected_pixels.pop_front();
                    bad = field_bad("pixel_index", 8'(px.pix), 8'(m_tdata[3:0]));
                    bad |= field_bad("red_byte", px.red, m_tdata[11:4]);
                    bad |= field_bad("green_byte", px.green, m_tdata[19:12]);
                    bad |= field_bad("blue_byte", px.blue, m_tdata[27:20]);
                    bad |= field_bad("alpha_byte", px.alpha, m_tdata[35:28]);
                    bad |= field_bad("last_pixel", 8'(px.last), 8'(m_tlast));
                    if (bad)
                        fail_count++;
                    pixels_checked++;
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// File: dv/tb_bc4_bc5_block_decoder.sv
// Top of the BC4/BC5 block decoder testbench: clock, reset, block stimulus under all
// four register settings, a stalling pixel sink, watchdog and verdict.
// Depends on bc45_pkg, bc4_bc5_block_decoder and bc4_bc5_block_decoder_checker.
`timescale 1ns / 1ps

module tb_bc4_bc5_block_decoder;
    import bc45_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    // index field with pixel p using index p mod 8, and its mirror
    localparam logic [47:0] INDEX_RAMP = 48'o7654321076543210;
    localparam logic [47:0] INDEX_FALL = 48'o0123456701234567;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_index;
    logic         cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tlast;

    int fail_count;
    int pending;
    int pixels_checked;
    int idle_max = 8;
    int blocks_sent = 0;
    int stuck_cycles = 0;

    always #10 clk = ~clk;

    bc4_bc5_block_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    bc4_bc5_block_decoder_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .pixels_checked(pixels_checked)
    );

    function automatic logic [63:0] channel_word(logic [7:0] e0, logic [7:0] e1,
                                                 logic [47:0] indices);
        return {indices, e1, e0};
    endfunction

    // Endpoints lean towards the signed and unsigned edges and towards e0 == e1.
    function automatic logic [63:0] random_channel_word();
        logic [7:0] edges [7];
        logic [7:0] e0;
        logic [7:0] e1;
        edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFE, 8'hFF};
        e0 = ($urandom_range(0, 3) == 0) ? edges[$urandom_range(0, 6)]
                                         : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       e1 = e0;
            1:       e1 = edges[$urandom_range(0, 6)];
            default: e1 = 8'($urandom_range(0, 255));
        endcase
        return channel_word(e0, e1, 48'({$urandom, $urandom}));
    endfunction

    // Entered and left at a falling edge.
    task automatic send_block(input logic [63:0] first, input logic [63:0] second);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {second, first};
        do @(posedge clk); while (!s_tready);
        blocks_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic configure(input logic snorm, input logic bc5);
        cfg_we <= 1'b1;
        cfg_index <= REG_SIGNED_FORMAT;
        cfg_data <= snorm;
        @(negedge clk);
        cfg_index <= REG_TWO_CHANNEL;
        cfg_data <= bc5;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_blocks(input int count);
        for (int k = 0; k < count; k++)
        begin
            // switch between stalling and back-to-back stretches
            if (k % 12 == 0)
                idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
            send_block(random_channel_word(), random_channel_word());
        end
    endtask

    initial
    begin : pixel_sink
        int gap;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = $urandom_range(0, idle_max);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb_bc4_bc5_block_decoder failed");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int failures;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_SIGNED_FORMAT;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unsigned BC4: both palette modes, equal endpoints, full-scale words
        configure(1'b0, 1'b0);
        send_block(channel_word(8'd200, 8'd10, INDEX_RAMP), {$urandom, $urandom});
        send_block(channel_word(8'd10, 8'd200, INDEX_RAMP), {$urandom, $urandom});
        send_block(channel_word(8'd77, 8'd77, INDEX_RAMP), {$urandom, $urandom});
        send_block(channel_word(8'hFF, 8'h00, INDEX_RAMP), {$urandom, $urandom});
        send_block(channel_word(8'h00, 8'hFF, INDEX_FALL), {$urandom, $urandom});
        send_block('1, '0);
        send_block('0, '1);
        send_random_blocks(30);

        // signed BC5: -128 folding, and the mode test on raw bytes
        wait_idle();
        configure(1'b1, 1'b1);
        send_block(channel_word(8'h7F, 8'h80, INDEX_RAMP),
                   channel_word(8'h80, 8'h7F, INDEX_FALL));
        send_block(channel_word(8'h80, 8'h81, INDEX_RAMP),
                   channel_word(8'h81, 8'h80, INDEX_RAMP));
        send_block(channel_word(8'h00, 8'hFF, INDEX_RAMP),
                   channel_word(8'hFF, 8'h00, INDEX_RAMP));
        send_block(channel_word(8'h80, 8'h80, INDEX_FALL),
                   channel_word(8'h7F, 8'h7F, INDEX_RAMP));
        send_block('1, '0);
        send_random_blocks(33);

        wait_idle();
        configure(1'b0, 1'b1);
        send_random_blocks(38);

        wait_idle();
        configure(1'b1, 1'b0);
        send_random_blocks(38);

        wait_idle();
        repeat (8) @(negedge clk);

        failures = fail_count + pending;
        $display("%0d blocks decoded, %0d pixel beats compared, %0d pixels never arrived",
                 blocks_sent, pixels_checked, pending);
        $display("register settings covered: unsigned/signed in both BC4 and BC5");
        if (failures == 0)
            $display("tb_bc4_bc5_block_decoder passed");
        else
            $display("tb_bc4_bc5_block_decoder failed");
        $finish;
    end

endmodule

// File: bc4_bc5_block_decoder.f
+incdir+design
design/bc45_pkg.sv
design/bc45_seq.sv
design/bc45_chan.sv
design/bc4_bc5_block_decoder.sv
dv/bc4_bc5_block_decoder_checker.sv
dv/tb_bc4_bc5_block_decoder.sv
